// ----- design/lfuc_pkg.sv -----
package lfuc_pkg;

  // Default build sizes
  localparam int ENTRIES_DEF    = 16;
  localparam int COUNT_BITS_DEF = 16;

  // Fixed field widths
  localparam int CAP_W = 5;
  localparam int KEY_W = 32;

  localparam logic [CAP_W-1:0] CAP_RESET  = 5'd16;
  localparam logic [KEY_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;

  typedef enum logic {
    OP_GET = 1'b0,
    OP_PUT = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_UPDATE,
    ST_RESULT
  } lfuc_state_e;

  // One request as latched by the engine
  typedef struct packed {
    op_e                     op;
    logic signed [KEY_W-1:0] key;
    logic signed [KEY_W-1:0] value;
  } req_t;

  // One result
  typedef struct packed {
    logic                    hit;
    logic signed [KEY_W-1:0] read_value;
    logic                    evicted;
    logic signed [KEY_W-1:0] evicted_key;
  } res_t;

endpackage

// ----- design/lfu_cache_lru_tiebreak.sv -----
// LFU key-value cache with LRU tie break.
// Request channel: in_valid_i with operation_i (get/put), lookup_key_i and
// store_value_i; a request is taken on a clock edge with in_valid_i high and
// in_stall_o low. Result channel: out_valid_o with hit_o, read_value_o,
// evicted_o and evicted_key_o; it is taken on an edge with out_stall_i low.
// Capacity is set through cfg_valid_i/cfg_ready_o/cfg_data_i (always ready).
// The user must write it only while no request is in flight; the block
// does not enforce this. Each request scans the entry memory through its
// single read port (match, victim, free slot); a put, or a get that hits,
// then makes a read-modify-write pass for counts and recency ranks. The
// next request is taken once the result moves into the output register.
// The result sits in an output register, so a new request is taken while
// the receiver stalls; that request finishes its work and then waits until
// the output register is free.
// Reset clears all valid bits and the fill count and sets capacity to 16;
// no clearing pass over the memory is needed.
module lfu_cache_lru_tiebreak import lfuc_pkg::*; #(
  parameter int ENTRIES    = ENTRIES_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CAP_W-1:0]        cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    operation_i,
  input  logic signed [KEY_W-1:0] lookup_key_i,
  input  logic signed [KEY_W-1:0] store_value_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic                    hit_o,
  output logic signed [KEY_W-1:0] read_value_o,
  output logic                    evicted_o,
  output logic signed [KEY_W-1:0] evicted_key_o
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int ENT_W = 2 * KEY_W + COUNT_BITS + IDX_W;

  logic [CAP_W-1:0] cap_q;
  logic             out_valid_q;
  res_t             out_q;

  req_t             req;
  logic             req_ready;
  logic             res_valid;
  logic             res_ready;
  res_t             res;

  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic [ENT_W-1:0] rd_data;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [ENT_W-1:0] wr_data;

  // Capacity register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_valid_i) begin
      cap_q <= cfg_data_i;
    end
  end

  // Request side
  assign req.op     = op_e'(operation_i);
  assign req.key    = lookup_key_i;
  assign req.value  = store_value_i;
  assign in_stall_o = !req_ready;

  lfuc_engine #(
    .ENTRIES    (ENTRIES),
    .COUNT_BITS (COUNT_BITS)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (in_valid_i),
    .req_ready_o (req_ready),
    .req_i       (req),
    .cap_i       (cap_q),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data)
  );

  lfuc_ram #(
    .DEPTH  (ENTRIES),
    .ADDR_W (IDX_W),
    .DATA_W (ENT_W)
  ) u_ram (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  // Output register
  assign res_ready = !out_valid_q || !out_stall_i;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign hit_o         = out_q.hit;
  assign read_value_o  = out_q.read_value;
  assign evicted_o     = out_q.evicted;
  assign evicted_key_o = out_q.evicted_key;

endmodule

// ----- design/lfuc_ram.sv -----
module lfuc_ram import lfuc_pkg::*; #(
  parameter int DEPTH  = ENTRIES_DEF,
  parameter int ADDR_W = 4,
  parameter int DATA_W = 8
) (
  input  logic              clk_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [DATA_W-1:0] rd_data_o,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [DATA_W-1:0] wr_data_i
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- design/lfuc_engine.sv -----
module lfuc_engine import lfuc_pkg::*; #(
  parameter int ENTRIES    = ENTRIES_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF,
  localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
  localparam int ENT_W  = 2 * KEY_W + COUNT_BITS + IDX_W,
  localparam int FILL_W = $clog2(ENTRIES + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  req_t              req_i,
  input  logic [CAP_W-1:0]  cap_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output res_t              res_o,
  output logic              rd_en_o,
  output logic [IDX_W-1:0]  rd_addr_o,
  input  logic [ENT_W-1:0]  rd_data_i,
  output logic              wr_en_o,
  output logic [IDX_W-1:0]  wr_addr_o,
  output logic [ENT_W-1:0]  wr_data_o
);

  localparam int CW = (FILL_W > CAP_W) ? FILL_W : CAP_W;
  localparam logic [IDX_W-1:0]      LAST      = IDX_W'(ENTRIES - 1);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  lfuc_state_e state_q, state_d;

  // Pass sequencing
  logic [IDX_W-1:0] addr_q;
  logic             issue_done_q;
  logic             rd_pend_q;
  logic [IDX_W-1:0] rd_idx_q;

  // Request and bookkeeping
  req_t               req_q;
  logic [ENTRIES-1:0] valid_q;
  logic [FILL_W-1:0]  fill_q;

  // Scan results
  logic                  found_q;
  logic [IDX_W-1:0]      sel_idx_q;
  logic [IDX_W-1:0]      sel_rank_q;
  logic [KEY_W-1:0]      sel_val_q;
  logic                  vic_ok_q;
  logic [IDX_W-1:0]      vic_idx_q;
  logic [COUNT_BITS-1:0] vic_cnt_q;
  logic [IDX_W-1:0]      vic_rank_q;
  logic [KEY_W-1:0]      vic_key_q;
  logic                  free_ok_q;
  logic [IDX_W-1:0]      free_idx_q;

  // Update target
  logic [IDX_W-1:0] tgt_q;
  logic [IDX_W-1:0] tgt_rank_q;
  logic             rank_all_q;
  res_t             res_q;

  // Entry fields on the read data
  logic [KEY_W-1:0]      e_key;
  logic [KEY_W-1:0]      e_value;
  logic [COUNT_BITS-1:0] e_count;
  logic [IDX_W-1:0]      e_rank;
  logic                  e_valid;
  logic                  last_idx;
  logic                  accept;
  logic                  vic_better;
  logic [CW-1:0]         cap_ext;
  logic [CW-1:0]         cap_eff;
  logic                  full;
  logic [COUNT_BITS-1:0] cnt_inc;

  assign e_key    = rd_data_i[ENT_W-1 -: KEY_W];
  assign e_value  = rd_data_i[ENT_W-KEY_W-1 -: KEY_W];
  assign e_count  = rd_data_i[IDX_W +: COUNT_BITS];
  assign e_rank   = rd_data_i[IDX_W-1:0];
  assign e_valid  = valid_q[rd_idx_q];
  assign last_idx = (rd_idx_q == LAST);
  assign accept   = req_valid_i && req_ready_o;

  // Least count wins, oldest among equal counts
  assign vic_better = !vic_ok_q || (e_count < vic_cnt_q) ||
                      ((e_count == vic_cnt_q) && (e_rank > vic_rank_q));

  // Effective capacity: zero acts as one, clamp to the built size
  assign cap_ext = CW'(cap_i);
  always_comb begin
    if (cap_i == '0) begin
      cap_eff = CW'(1);
    end else if (cap_ext > CW'(ENTRIES)) begin
      cap_eff = CW'(ENTRIES);
    end else begin
      cap_eff = cap_ext;
    end
  end
  assign full = (CW'(fill_q) >= cap_eff);

  assign cnt_inc = (e_count == COUNT_MAX) ? e_count : e_count + COUNT_BITS'(1);

  // Next state and handshakes
  always_comb begin
    state_d     = state_q;
    req_ready_o = 1'b0;
    res_valid_o = 1'b0;
    rd_en_o     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        rd_en_o = !issue_done_q;
        if (rd_pend_q && last_idx) state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (found_q || req_q.op == OP_PUT) begin
          state_d = ST_UPDATE;
        end else begin
          state_d = ST_RESULT;
        end
      end
      ST_UPDATE: begin
        rd_en_o = !issue_done_q;
        if (rd_pend_q && last_idx) state_d = ST_RESULT;
      end
      ST_RESULT: begin
        res_valid_o = 1'b1;
        if (res_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign rd_addr_o = addr_q;
  assign res_o     = res_q;

  // Write-back during the update pass
  assign wr_en_o   = (state_q == ST_UPDATE) && rd_pend_q;
  assign wr_addr_o = rd_idx_q;
  always_comb begin
    if (rd_idx_q == tgt_q) begin
      if (found_q) begin
        wr_data_o = {e_key, (req_q.op == OP_PUT) ? req_q.value : e_value,
                     cnt_inc, IDX_W'(0)};
      end else begin
        wr_data_o = {req_q.key, req_q.value, COUNT_BITS'(1), IDX_W'(0)};
      end
    end else if (e_valid && (rank_all_q || e_rank < tgt_rank_q)) begin
      wr_data_o = {e_key, e_value, e_count, e_rank + IDX_W'(1)};
    end else begin
      wr_data_o = rd_data_i;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      addr_q       <= '0;
      issue_done_q <= 1'b0;
      rd_pend_q    <= 1'b0;
      valid_q      <= '0;
      fill_q       <= '0;
      found_q      <= 1'b0;
      vic_ok_q     <= 1'b0;
      free_ok_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_pend_q <= rd_en_o;

      // Address walk, restarted before each pass
      if (state_q == ST_IDLE || state_q == ST_DECIDE) begin
        addr_q       <= '0;
        issue_done_q <= 1'b0;
      end else if (rd_en_o) begin
        if (addr_q == LAST) begin
          issue_done_q <= 1'b1;
        end else begin
          addr_q <= addr_q + IDX_W'(1);
        end
      end

      // Scan flags
      if (accept) begin
        found_q   <= 1'b0;
        vic_ok_q  <= 1'b0;
        free_ok_q <= 1'b0;
      end else if (state_q == ST_SCAN && rd_pend_q) begin
        if (e_valid) begin
          if (e_key == req_q.key) found_q <= 1'b1;
          if (vic_better) vic_ok_q <= 1'b1;
        end else begin
          free_ok_q <= 1'b1;
        end
      end

      // New entry into a free slot
      if (state_q == ST_DECIDE && !found_q && req_q.op == OP_PUT &&
          !(full && vic_ok_q)) begin
        valid_q[free_idx_q] <= 1'b1;
        fill_q              <= fill_q + FILL_W'(1);
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    rd_idx_q <= addr_q;
    if (accept) begin
      req_q <= req_i;
    end

    // Scan: first match, victim, first free slot
    if (state_q == ST_SCAN && rd_pend_q) begin
      if (e_valid) begin
        if (!found_q && e_key == req_q.key) begin
          sel_idx_q  <= rd_idx_q;
          sel_rank_q <= e_rank;
          sel_val_q  <= e_value;
        end
        if (vic_better) begin
          vic_idx_q  <= rd_idx_q;
          vic_cnt_q  <= e_count;
          vic_rank_q <= e_rank;
          vic_key_q  <= e_key;
        end
      end else if (!free_ok_q) begin
        free_idx_q <= rd_idx_q;
      end
    end

    // Decide the target and the result
    if (state_q == ST_DECIDE) begin
      res_q.hit         <= found_q;
      res_q.read_value  <= '0;
      res_q.evicted     <= 1'b0;
      res_q.evicted_key <= '0;
      rank_all_q        <= 1'b0;
      if (found_q) begin
        tgt_q      <= sel_idx_q;
        tgt_rank_q <= sel_rank_q;
        if (req_q.op == OP_GET) res_q.read_value <= sel_val_q;
      end else if (req_q.op == OP_GET) begin
        res_q.read_value <= MISS_VALUE;
      end else if (full && vic_ok_q) begin
        // Victim slot is reused; entries newer than it age by one
        tgt_q             <= vic_idx_q;
        tgt_rank_q        <= vic_rank_q;
        res_q.evicted     <= 1'b1;
        res_q.evicted_key <= vic_key_q;
      end else begin
        tgt_q      <= free_idx_q;
        tgt_rank_q <= '0;
        rank_all_q <= 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_same_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en_o && rd_en_o) |-> (wr_addr_o != rd_addr_o))
    else $error("read and write of one entry in the same cycle");

  a_fill_tracks_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q == FILL_W'($countones(valid_q)))
    else $error("fill count out of step with valid bits");

  a_evict_only_put_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.evicted) |-> (!res_o.hit && req_q.op == OP_PUT))
    else $error("eviction on a hit or a get");

  a_insert_has_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DECIDE && !found_q && req_q.op == OP_PUT && !full)
      |-> free_ok_q)
    else $error("no free slot for an insert below capacity");
`endif

endmodule
